// ===== rtl/core/rtt_pkg.sv =====
// Shared types, constants and helpers for the radix text-to-integer parser.
// Used by rtt_front, rtt_fifo, rtt_back and radix_text_to_integer.
package rtt_pkg;

  localparam int unsigned AccWidth   = 64;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned DigitWidth = 6;

  localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;
  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;

  // Register index of the radix register in the configuration space.
  localparam logic RegRadix = 1'b0;

  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] Chr0     = 8'h30;
  localparam logic [7:0] Chr9     = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5A;
  localparam logic [7:0] ChrLoA   = 8'h61;
  localparam logic [7:0] ChrLoZ   = 8'h7A;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_BLANK,
    CLS_DIGIT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_OTHER
  } char_cls_e;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } parse_phase_e;

  typedef struct packed {
    char_cls_e             cls;
    logic [DigitWidth-1:0] digit;
    logic                  last;
  } rtt_item_t;

  // Clamp the raw register value into 2..36.
  function automatic logic [RadixWidth-1:0] eff_radix(input logic [RadixWidth-1:0] raw);
    logic [RadixWidth-1:0] r;
    r = raw;
    if (raw < RadixMin) r = RadixMin;
    else if (raw > RadixMax) r = RadixMax;
    return r;
  endfunction

endpackage

// ===== rtl/core/rtt_front.sv =====
// Front end: accepts characters and classifies them into items for the queue.
// Depends on rtt_pkg for the item type and character constants.
module rtt_front (
  input  logic [7:0]                   char_code_i,
  input  logic                         char_present_i,
  input  logic                         last_char_i,
  input  logic [rtt_pkg::RadixWidth-1:0] radix_i,
  output logic                         keep_o,
  output rtt_pkg::rtt_item_t           item_o
);

  logic [7:0] dig_raw;
  logic       is_alnum;

  always_comb begin
    is_alnum = 1'b1;
    dig_raw  = 8'd0;
    if (char_code_i >= rtt_pkg::Chr0 && char_code_i <= rtt_pkg::Chr9) begin
      dig_raw = char_code_i - rtt_pkg::Chr0;
    end else if (char_code_i >= rtt_pkg::ChrUpA && char_code_i <= rtt_pkg::ChrUpZ) begin
      dig_raw = char_code_i - rtt_pkg::ChrUpA + 8'd10;
    end else if (char_code_i >= rtt_pkg::ChrLoA && char_code_i <= rtt_pkg::ChrLoZ) begin
      dig_raw = char_code_i - rtt_pkg::ChrLoA + 8'd10;
    end else begin
      is_alnum = 1'b0;
    end
  end

  always_comb begin
    item_o.last  = last_char_i;
    item_o.digit = dig_raw[rtt_pkg::DigitWidth-1:0];
    if (!char_present_i) begin
      item_o.cls = rtt_pkg::CLS_NONE;
    end else if (char_code_i == rtt_pkg::ChrSpace || char_code_i == rtt_pkg::ChrLf ||
                 char_code_i == rtt_pkg::ChrCr || char_code_i == rtt_pkg::ChrTab) begin
      item_o.cls = rtt_pkg::CLS_BLANK;
    end else if (is_alnum && dig_raw[rtt_pkg::DigitWidth-1:0] < radix_i) begin
      item_o.cls = rtt_pkg::CLS_DIGIT;
    end else if (char_code_i == rtt_pkg::ChrPlus) begin
      item_o.cls = rtt_pkg::CLS_PLUS;
    end else if (char_code_i == rtt_pkg::ChrMinus) begin
      item_o.cls = rtt_pkg::CLS_MINUS;
    end else begin
      item_o.cls = rtt_pkg::CLS_OTHER;
    end
  end

  // Drop empty items that do not end a literal.
  assign keep_o = char_present_i | last_char_i;

endmodule

// ===== rtl/core/rtt_fifo.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on rtt_pkg for the item type.
module rtt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rtt_pkg::rtt_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rtt_pkg::rtt_item_t pop_item_o
);

  rtt_pkg::rtt_item_t mem_q [2];
  logic               wptr_q, wptr_d;
  logic               rptr_q, rptr_d;
  logic [1:0]         count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    else if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_item_i;
  end

endmodule

// ===== rtl/core/rtt_back.sv =====
// Back end: runs the parse phase machine and the multiply-add accumulator,
// and holds the finished result in an output register. Depends on rtt_pkg.
module rtt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rtt_pkg::RadixWidth-1:0] radix_i,
  input  logic                           valid_i,
  input  rtt_pkg::rtt_item_t             item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rtt_pkg::AccWidth-1:0]   value_o,
  output logic                           status_o,
  output logic                           overflowed_o
);

  localparam int unsigned ProdWidth = rtt_pkg::AccWidth + rtt_pkg::RadixWidth + 1;

  rtt_pkg::parse_phase_e         phase_q, phase_d, phase_nx;
  logic                          neg_q, neg_d, neg_nx;
  logic [rtt_pkg::AccWidth-1:0]  mag_q, mag_d, mag_nx;
  logic                          ovf_q, ovf_d, ovf_nx;
  logic                          acc_en, sign_en;
  logic [ProdWidth-1:0]          prod;
  logic                          take;

  logic                          out_valid_q, out_valid_d;
  logic [rtt_pkg::AccWidth-1:0]  value_q, value_d;
  logic                          status_q, status_d;
  logic                          ovfo_q, ovfo_d;

  // Take an item unless it ends a literal and the output register is still held.
  assign take  = valid_i & (~item_i.last | ~out_valid_q | out_ready_i);
  assign pop_o = take;

  // Next phase
  always_comb begin
    phase_nx = phase_q;
    unique case (item_i.cls) inside
      rtt_pkg::CLS_NONE: phase_nx = phase_q;
      rtt_pkg::CLS_BLANK: begin
        unique case (phase_q) inside
          rtt_pkg::PH_LEAD: phase_nx = rtt_pkg::PH_LEAD;
          rtt_pkg::PH_DIGITS, rtt_pkg::PH_TRAIL: phase_nx = rtt_pkg::PH_TRAIL;
          default: phase_nx = rtt_pkg::PH_BAD;
        endcase
      end
      rtt_pkg::CLS_DIGIT: begin
        unique case (phase_q) inside
          rtt_pkg::PH_LEAD, rtt_pkg::PH_SIGN, rtt_pkg::PH_DIGITS:
            phase_nx = rtt_pkg::PH_DIGITS;
          default: phase_nx = rtt_pkg::PH_BAD;
        endcase
      end
      rtt_pkg::CLS_PLUS, rtt_pkg::CLS_MINUS: begin
        phase_nx = (phase_q == rtt_pkg::PH_LEAD) ? rtt_pkg::PH_SIGN : rtt_pkg::PH_BAD;
      end
      default: phase_nx = rtt_pkg::PH_BAD;
    endcase
  end

  // Datapath controls from the current phase
  always_comb begin
    acc_en  = 1'b0;
    sign_en = 1'b0;
    unique case (phase_q) inside
      rtt_pkg::PH_LEAD: begin
        acc_en  = (item_i.cls == rtt_pkg::CLS_DIGIT);
        sign_en = (item_i.cls == rtt_pkg::CLS_PLUS) || (item_i.cls == rtt_pkg::CLS_MINUS);
      end
      rtt_pkg::PH_SIGN, rtt_pkg::PH_DIGITS: acc_en = (item_i.cls == rtt_pkg::CLS_DIGIT);
      default: begin
        acc_en  = 1'b0;
        sign_en = 1'b0;
      end
    endcase
  end

  assign prod = {{(ProdWidth-rtt_pkg::AccWidth){1'b0}}, mag_q}
              * {{(ProdWidth-rtt_pkg::RadixWidth){1'b0}}, radix_i}
              + {{(ProdWidth-rtt_pkg::DigitWidth){1'b0}}, item_i.digit};

  always_comb begin
    neg_nx = sign_en ? (item_i.cls == rtt_pkg::CLS_MINUS) : neg_q;
    mag_nx = acc_en ? prod[rtt_pkg::AccWidth-1:0] : mag_q;
    ovf_nx = ovf_q | (acc_en & (|prod[ProdWidth-1:rtt_pkg::AccWidth]));
  end

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    value_d     = value_q;
    status_d    = status_q;
    ovfo_d      = ovfo_q;
    if (take) begin
      if (item_i.last) begin
        // Emit the result and clear the literal state.
        phase_d     = rtt_pkg::PH_LEAD;
        neg_d       = 1'b0;
        mag_d       = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
        if (phase_nx == rtt_pkg::PH_DIGITS || phase_nx == rtt_pkg::PH_TRAIL) begin
          value_d  = neg_nx ? (~mag_nx + 64'd1) : mag_nx;
          status_d = 1'b0;
          ovfo_d   = ovf_nx;
        end else begin
          value_d  = '0;
          status_d = 1'b1;
          ovfo_d   = 1'b0;
        end
      end else begin
        phase_d = phase_nx;
        neg_d   = neg_nx;
        mag_d   = mag_nx;
        ovf_d   = ovf_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rtt_pkg::PH_LEAD;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    ovfo_q   <= ovfo_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign overflowed_o = ovfo_q;

endmodule

// ===== rtl/core/radix_text_to_integer.sv =====
// Radix text-to-integer parser: one character per item in, one value per literal out.
// Uses rtt_pkg, rtt_front, rtt_fifo and rtt_back.
//
// Input stream: s_axis_tdata carries one byte of the literal, s_axis_tuser
// flags that the byte is present (clear for an empty end marker), and
// s_axis_tlast marks the final item of the literal. Items without a byte that
// are not last are dropped.
// Output stream: one item per literal, issued for the item that carries tlast.
// m_axis_tdata is the signed 64-bit value (wrapped); m_axis_tuser holds the
// status (set for an invalid literal, value then zero) and the overflow flag.
// APB register 0 (address 0) holds the radix; values below 2 act as 2 and
// above 36 act as 36. Reset value is 10. Write only while the block is idle.
// Throughput: one item per cycle while the output register is not held. The
// back end updates the accumulator with a combinational 64x6 multiply-add,
// which sets that rate. Result path: after its last item is accepted, a result
// passes through the two-entry queue and then the output register.
// Reset clears the queue, the parse state and the output valid flag; the radix
// returns to 10. When the receiver stalls, the result is held and characters
// keep flowing until the next last item waits at the head of the queue and one
// more item fills the queue; then s_axis_tready drops.
module radix_text_to_integer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] char_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [1:0]  m_axis_tuser,   // [0] status, [1] overflowed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [rtt_pkg::RadixWidth-1:0] radix_q, radix_d;
  logic [rtt_pkg::RadixWidth-1:0] radix_eff;
  logic                           reg_wr;

  logic               keep;
  rtt_pkg::rtt_item_t front_item;
  rtt_pkg::rtt_item_t back_item;
  logic               q_full, q_valid, q_pop;
  logic               status, ovf;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == rtt_pkg::RegRadix);
  assign radix_d = reg_wr ? pwdata[rtt_pkg::RadixWidth-1:0] : radix_q;
  assign prdata = (paddr[2] == rtt_pkg::RegRadix)
                ? {{(32-rtt_pkg::RadixWidth){1'b0}}, radix_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rtt_pkg::RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign radix_eff = rtt_pkg::eff_radix(radix_q);

  rtt_front u_front (
    .char_code_i    (s_axis_tdata),
    .char_present_i (s_axis_tuser),
    .last_char_i    (s_axis_tlast),
    .radix_i        (radix_eff),
    .keep_o         (keep),
    .item_o         (front_item)
  );

  assign s_axis_tready = ~q_full;

  rtt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid & keep),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (back_item)
  );

  rtt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_eff),
    .valid_i      (q_valid),
    .item_i       (back_item),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .value_o      (m_axis_tdata),
    .status_o     (status),
    .overflowed_o (ovf)
  );

  assign m_axis_tuser = {ovf, status};

endmodule
